>>> rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 stream transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_TOO_BIG  = 2'd3;

  // Code point limits and surrogate bases.
  localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_PLANE1   = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

  // Depth of the queue between the decoder and the emitter.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        run_last;
    logic        string_done;
  } unit_item_t;

  // One decoded request: a single result, or a surrogate pair.
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        pair;
    logic [1:0]  status;
    logic        done;
  } job_t;

endpackage

>>> rtl/utf8_to_utf16_stream_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_core
// UTF-8 byte stream in, UTF-16 code units out, with per-string error status.
// ----------------------------------------------------------------------------
// Usage. Bytes enter on the byte channel, which behaves like the write side
// of a queue: a request is taken on a clock edge with push high and full low.
// The flag string_end marks the last byte of a string. Code units leave on
// the unit channel, the read side of a queue: while empty is low the oldest
// result sits on unit_item, and pop high on a clock edge takes it.
// Each byte gives no result (a lead or middle byte of a sequence, or a byte
// dropped after an error), one code unit, two units for a surrogate pair, or
// one error result with a zero unit and string_done set.
// A result reaches unit_item through the job queue and the output register:
// the job enters the queue on the edge that takes the byte completing it,
// and moves into the output register once that register is free.
// Throughput: one byte per cycle while full is low. A surrogate pair fills
// the output register twice, so the queue keeps one extra job; when the byte
// right after the pair also makes a result, full rises for one cycle.
// Otherwise full rises only when the receiver stops popping.
// When the receiver stalls, the output register holds its result, the queue
// fills, and then full holds off further bytes; nothing is lost.
// Reset (rst, synchronous) clears the decoder state and empties the queue and
// the output register. Units already sent for a string that later fails
// cannot be recalled, so the receiver drops such a string.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  u8u16_pkg::byte_item_t byte_item,
  output logic                  empty,
  input  logic                  pop,
  output u8u16_pkg::unit_item_t unit_item
);
  import u8u16_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  logic head_valid;
  job_t head_job;
  logic head_take;
  logic out_valid;

  // A byte is taken whenever the job queue has room, even if it makes no job.
  assign accept = push && !full;
  assign empty  = !out_valid;

  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_item),
    .job_valid (job_valid),
    .job       (job)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept && job_valid),
    .wr_job     (job),
    .rd_en      (head_take),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (full)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .head_take  (head_take),
    .out_valid  (out_valid),
    .out_item   (unit_item),
    .out_take   (pop)
  );

`ifndef ASSERT_OFF
  // The first half of a pair is always a high surrogate and never ends a string.
  a_first_half: assert property (@(posedge clk) disable iff (rst)
    (!empty && !unit_item.run_last) |->
      (!unit_item.string_done && unit_item.code_unit[15:10] == HI_SURR_TAG))
    else $error("first half of pair is not a high surrogate");

  // Once the high surrogate is taken, the low surrogate follows at once.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !unit_item.run_last) |=>
      (!empty && unit_item.code_unit[15:10] == LO_SURR_TAG))
    else $error("low surrogate did not follow high surrogate");

  // Error results carry a zero unit and close the string.
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && unit_item.status != ST_OK) |->
      (unit_item.code_unit == 16'd0 && unit_item.string_done && unit_item.run_last))
    else $error("malformed error result");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");
`endif

endmodule

>>> rtl/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Decoder: takes one byte per request, tracks the sequence state and hands
// each finished code point or error to the queue as one job.
// ----------------------------------------------------------------------------
module u8u16_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  u8u16_pkg::byte_item_t item,
  output logic                  job_valid,
  output u8u16_pkg::job_t       job
);
  import u8u16_pkg::*;

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] point_accum, point_accum_next;
  logic        skip_to_end, skip_to_end_next;

  logic [20:0] shifted;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic        do_emit;
  logic        do_fail;
  logic [1:0]  fail_status;
  logic        end_flag;

  assign end_flag = item.string_end;
  assign shifted  = {point_accum[14:0], item.in_byte[5:0]};
  assign cp_off   = cp - CP_PLANE1;

  always_comb begin
    bytes_pending_next = bytes_pending;
    point_accum_next   = point_accum;
    skip_to_end_next   = skip_to_end;
    cp                 = shifted;
    do_emit            = 1'b0;
    do_fail            = 1'b0;
    fail_status        = ST_OK;

    if (skip_to_end) begin
      if (end_flag) begin
        skip_to_end_next = 1'b0;
      end
    end else if (bytes_pending == 2'd0) begin
      if (!item.in_byte[7]) begin
        cp      = {13'd0, item.in_byte};
        do_emit = 1'b1;
      end else begin
        if (item.in_byte[7:5] == 3'b110) begin
          point_accum_next   = {16'd0, item.in_byte[4:0]};
          bytes_pending_next = 2'd1;
        end else if (item.in_byte[7:4] == 4'b1110) begin
          point_accum_next   = {17'd0, item.in_byte[3:0]};
          bytes_pending_next = 2'd2;
        end else if (item.in_byte[7:3] == 5'b11110) begin
          point_accum_next   = {18'd0, item.in_byte[2:0]};
          bytes_pending_next = 2'd3;
        end else begin
          do_fail     = 1'b1;
          fail_status = ST_BAD_LEAD;
        end
        if (!do_fail && end_flag) begin
          do_fail     = 1'b1;
          fail_status = ST_TRUNC;
        end
      end
    end else begin
      point_accum_next   = shifted;
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        point_accum_next = '0;
        cp               = shifted;
        do_emit          = 1'b1;
      end else if (end_flag) begin
        do_fail     = 1'b1;
        fail_status = ST_TRUNC;
      end
    end

    // A code point beyond the last plane turns into an error.
    if (do_emit && (cp > CP_MAX)) begin
      do_emit     = 1'b0;
      do_fail     = 1'b1;
      fail_status = ST_TOO_BIG;
    end

    if (do_fail) begin
      bytes_pending_next = 2'd0;
      point_accum_next   = '0;
      skip_to_end_next   = !end_flag;
    end
  end

  always_comb begin
    job        = '0;
    job_valid  = do_emit || do_fail;
    job.done   = end_flag;
    job.status = ST_OK;
    if (do_fail) begin
      job.status = fail_status;
      job.done   = 1'b1;
    end else if (cp <= CP_BMP_MAX) begin
      job.unit0 = cp[15:0];
    end else begin
      job.pair  = 1'b1;
      job.unit0 = {HI_SURR_TAG, cp_off[19:10]};
      job.unit1 = {LO_SURR_TAG, cp_off[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      point_accum   <= '0;
      skip_to_end   <= 1'b0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      point_accum   <= point_accum_next;
      skip_to_end   <= skip_to_end_next;
    end
  end

endmodule

>>> rtl/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Short job queue that decouples the decoder from the emitter.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  u8u16_pkg::job_t wr_job,
  input  logic            rd_en,
  output logic            head_valid,
  output u8u16_pkg::job_t head_job,
  output logic            full
);
  import u8u16_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && head_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Emitter: turns queued jobs into result requests, two for a surrogate pair,
// through a registered output stage.
// ----------------------------------------------------------------------------
module u8u16_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  u8u16_pkg::job_t       head_job,
  output logic                  head_take,
  output logic                  out_valid,
  output u8u16_pkg::unit_item_t out_item,
  input  logic                  out_take
);
  import u8u16_pkg::*;

  logic       phase;
  logic       load;
  logic       first_half;
  unit_item_t next_item;

  assign load       = (!out_valid || out_take) && head_valid;
  assign first_half = head_job.pair && !phase;
  assign head_take  = load && !first_half;

  always_comb begin
    next_item.status = head_job.status;
    if (first_half) begin
      next_item.code_unit   = head_job.unit0;
      next_item.run_last    = 1'b0;
      next_item.string_done = 1'b0;
    end else begin
      next_item.code_unit   = phase ? head_job.unit1 : head_job.unit0;
      next_item.run_last    = 1'b1;
      next_item.string_done = head_job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= first_half;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= next_item;
    end
  end

endmodule

>>> test/utf8_to_utf16_stream_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_core_tb
// Self-checking bench for the UTF-8 to UTF-16 stream transcoder.
// ----------------------------------------------------------------------------
// A queue of UTF-8 bytes is built up front. It starts with hand-picked
// sequences at the edges of each length class and each error. It then
// continues with random strings: mostly well formed, some with an error in
// them, and some raw noise. A clocked driver pushes the bytes in bursts. Each
// accepted request is decoded by a behavioral predictor, which queues the
// code units it expects. A clocked monitor pops results on a stall pattern of
// its own and compares each one, field by field, against the oldest
// expectation. A watchdog ends the run if no request moves on either side for
// too long.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_core_tb;
  import u8u16_pkg::*;

  // Cycles without any accepted request before the run is declared hung. The
  // long receiver hold-off below is far shorter than this.
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 250;
  localparam int STIM_BYTES   = 1775;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  byte_item_t byte_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  unit_item_t unit_item;

  utf8_to_utf16_stream_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .empty     (empty),
    .pop       (pop),
    .unit_item (unit_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes still to be sent, and code units the decoder is expected to emit.
  byte_item_t pending_bytes[$];
  unit_item_t expected_units[$];

  int mismatches = 0;
  int bytes_taken = 0;

  // Hooks through which the stimulus process applies pressure.
  bit tx_pause = 1'b0;
  bit long_hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor state: continuation bytes still owed, the code point bits seen
  // so far, and whether the rest of the current string is being dropped.
  // --------------------------------------------------------------------------
  logic [1:0]  cont_left = '0;
  logic [20:0] cp_acc = '0;
  logic        dropping = 1'b0;

  function automatic unit_item_t make_unit(input logic [15:0] cu, input logic [1:0] st,
                                           input logic lst, input logic dn);
    unit_item_t u;
    u.code_unit   = cu;
    u.status      = st;
    u.run_last    = lst;
    u.string_done = dn;
    return u;
  endfunction

  // Appends one unit to the tail of the expectation queue.
  task automatic queue_unit(input unit_item_t u);
    expected_units.insert(expected_units.size(), u);
  endtask

  // An error clears the decoder and, unless it fell on the string's last
  // byte, drops everything up to that last byte.
  task automatic raise_error(input logic [1:0] st, input logic fin);
    cont_left = '0;
    cp_acc    = '0;
    dropping  = !fin;
    queue_unit(make_unit(16'd0, st, 1'b1, 1'b1));
  endtask

  // A finished code point becomes one unit, a surrogate pair, or an error if
  // it lies beyond the Unicode range.
  task automatic emit_point(input logic [20:0] cp, input logic fin);
    logic [20:0] off;
    if (cp <= CP_BMP_MAX) begin
      queue_unit(make_unit(cp[15:0], ST_OK, 1'b1, fin));
    end else if (cp > CP_MAX) begin
      raise_error(ST_TOO_BIG, fin);
    end else begin
      off = cp - CP_PLANE1;
      queue_unit(make_unit({HI_SURR_TAG, off[19:10]}, ST_OK, 1'b0, 1'b0));
      queue_unit(make_unit({LO_SURR_TAG, off[9:0]}, ST_OK, 1'b1, fin));
    end
  endtask

  task automatic transcode_byte(input byte_item_t it);
    logic [7:0]  b;
    logic        fin;
    logic [20:0] cp;
    b   = it.in_byte;
    fin = it.string_end;
    if (dropping) begin
      if (fin) dropping = 1'b0;
    end else if (cont_left == 2'd0) begin
      if (!b[7]) begin
        emit_point({13'd0, b}, fin);
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        if (b[7:5] == 3'b110) begin
          cp_acc    = {16'd0, b[4:0]};
          cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          cp_acc    = {17'd0, b[3:0]};
          cont_left = 2'd2;
        end else begin
          cp_acc    = {18'd0, b[2:0]};
          cont_left = 2'd3;
        end
        // A lead byte that ends the string leaves the sequence cut short.
        if (fin) raise_error(ST_TRUNC, fin);
      end else begin
        // Stray continuation bytes and 0xF8..0xFF cannot start a sequence.
        raise_error(ST_BAD_LEAD, fin);
      end
    end else begin
      // Continuation bytes contribute their low six bits; the tag bits on
      // top are deliberately ignored by the decoder.
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        cp     = cp_acc;
        cp_acc = '0;
        emit_point(cp, fin);
      end else if (fin) begin
        raise_error(ST_TRUNC, fin);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders.
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b, input logic fin);
    byte_item_t it;
    it.in_byte    = b;
    it.string_end = fin;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  // Queues the first 'keep' bytes of the n-byte encoding of cp. The encoding
  // may be overlong, and now and then a continuation byte gets a wrong tag.
  task automatic add_seq(input logic [20:0] cp, input int n, input int keep,
                         input logic fin);
    logic [7:0]  enc [4];
    logic [20:0] part;
    logic [1:0]  tag;
    int          i;
    case (n)
      1: enc[0] = {1'b0, cp[6:0]};
      2: enc[0] = {3'b110, cp[10:6]};
      3: enc[0] = {4'b1110, cp[15:12]};
      default: enc[0] = {5'b11110, cp[20:18]};
    endcase
    for (i = 1; i < n; i++) begin
      part = cp >> (6 * (n - 1 - i));
      tag  = ($urandom_range(0, 19) == 0) ? 2'($urandom) : 2'b10;
      enc[i] = {tag, part[5:0]};
    end
    for (i = 0; i < keep; i++) add_byte(enc[i], fin && (i == keep - 1));
  endtask

  function automatic logic [20:0] pick_point(input int n);
    logic [20:0] cp;
    case (n)
      1: cp = 21'($urandom_range(0, 8'h7F));
      2: cp = 21'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8'h7F)
                                              : $urandom_range(12'h080, 12'h7FF));
      3: begin
        if ($urandom_range(0, 9) == 0) cp = 21'($urandom_range(0, 12'h7FF));
        else if ($urandom_range(0, 7) == 0) cp = 21'($urandom_range(16'hD800, 16'hDFFF));
        else cp = 21'($urandom_range(12'h800, 16'hFFFF));
      end
      default: cp = 21'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16'hFFFF)
                                                    : $urandom_range(21'h10000, 21'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic logic [7:0] pick_bad_lead();
    return 8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                   : $urandom_range(8'hF8, 8'hFF));
  endfunction

  // One random string. Most are well formed; some carry a single error
  // somewhere in them; a few are raw noise.
  task automatic add_random_string();
    int kind, len, bad_at, n, i;
    logic lst;
    kind = $urandom_range(0, 99);
    if (kind < 95) begin
      len    = $urandom_range(1, 6);
      bad_at = (kind < 80) ? -1 : $urandom_range(0, len - 1);
      for (i = 0; i < len; i++) begin
        lst = (i == len - 1);
        n   = $urandom_range(1, 4);
        if (i != bad_at) begin
          add_seq(pick_point(n), n, n, lst);
        end else begin
          case ($urandom_range(0, 2))
            0: add_byte(pick_bad_lead(), lst);
            1: add_seq(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4, lst);
            default: begin
              // Cut the sequence short and end the string right there.
              if (n == 1) n = $urandom_range(2, 4);
              add_seq(pick_point(n), n, $urandom_range(1, n - 1), 1'b1);
              i = len;
            end
          endcase
        end
      end
    end else begin
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++)
        add_byte(8'($urandom), (i == len - 1) || ($urandom_range(0, 7) == 0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next pending byte in bursts separated by random gaps.
  // Every third stretch of about 300 bytes is sent with no gaps at all. An
  // offered byte stays on the port until it is taken.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;
  logic offer;

  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (push && !full) begin
        transcode_byte(pending_bytes.pop_front());
        bytes_taken++;
        burst_left--;
        if (burst_left <= 0)
          gap_left = ((bytes_taken / 300) % 3 == 1) ? 0 : $urandom_range(1, 12);
      end
      if (!(push && full)) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!tx_pause && pending_bytes.size() > 0) begin
          if (burst_left <= 0) burst_left = $urandom_range(1, 32);
          offer = 1'b1;
        end
        push <= offer;
        if (offer) byte_item <= pending_bytes[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each popped result and decides the next pop. The pop
  // style is redrawn periodically: steady, a repeating 8-bit mask, or
  // random. A long hold-off request overrides the style, holding pops off as set by LONG_HOLD.
  // --------------------------------------------------------------------------
  int          rx_cycle = 0;
  int          hold_left = 0;
  int          pop_style = 0;
  logic [7:0]  pop_mask = 8'hFF;
  logic        take;
  unit_item_t  want;

  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      rx_cycle = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_units.size() == 0) begin
          $error("unexpected result: code_unit %h status %0d", unit_item.code_unit,
                 unit_item.status);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (unit_item.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, unit_item.code_unit);
            mismatches++;
          end
          if (unit_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, unit_item.status);
            mismatches++;
          end
          if (unit_item.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, unit_item.run_last);
            mismatches++;
          end
          if (unit_item.string_done !== want.string_done) begin
            $error("string_done: expected %0d, got %0d", want.string_done,
                   unit_item.string_done);
            mismatches++;
          end
        end
      end

      if (rx_cycle % 128 == 0) begin
        pop_style = $urandom_range(0, 3);
        pop_mask  = 8'($urandom) | 8'h01;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (pop_style)
          0: take = 1'b1;
          1: take = pop_mask[rx_cycle % 8];
          2: take = ($urandom_range(0, 3) != 0);
          default: take = 1'($urandom_range(0, 1));
        endcase
      end
      pop <= take;
      rx_cycle++;
    end
  end

  // Watchdog: counts cycles in which no request moves on either side.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("utf8_to_utf16_stream_core_tb NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and run control.
  // --------------------------------------------------------------------------
  initial begin
    // Directed strings: a zero byte, the largest unit of each length class, the top of
    // the Unicode range as a surrogate pair, a code point past that range,
    // a stray continuation byte whose string is then dropped, a lead byte
    // that can never start a sequence, sequences cut short on a lead and a
    // middle byte, an encoded surrogate passed through, and an overlong
    // form with an untagged continuation byte.
    add_byte(8'h00, 1'b1);
    add_byte(8'h7F, 1'b1);
    add_byte(8'hDF, 1'b0); add_byte(8'hBF, 1'b1);
    add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b1);
    add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);
    add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);
    add_byte(8'h80, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h42, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hF0, 1'b1);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
    add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b1);
    add_byte(8'hC0, 1'b0); add_byte(8'h00, 1'b1);
    while (pending_bytes.size() < STIM_BYTES) add_random_string();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Hold the receiver off for a long stretch while bytes keep coming, so
    // the job queue fills and full backs up the sender.
    while (bytes_taken < 400) @(negedge clk);
    long_hold_req = 1'b1;

    // Later, stop sending until every expected unit has been drained.
    while (bytes_taken < 1000) @(negedge clk);
    tx_pause = 1'b1;
    while (push || expected_units.size() != 0) @(negedge clk);
    tx_pause = 1'b0;

    while (push || pending_bytes.size() != 0) @(negedge clk);
    while (expected_units.size() != 0) @(negedge clk);
    // A few more cycles so that a spurious trailing result would be seen.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("utf8_to_utf16_stream_core_tb OK");
    end else begin
      $display("utf8_to_utf16_stream_core_tb NOT OK");
    end
    $finish;
  end

endmodule
